// ----- src/strp_pkg.sv -----
// Shared types and constants for the string-to-unsigned parser.
package strp_pkg;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_OVERFLOW  = 2'd1;
    localparam status_t STATUS_NO_DIGITS = 2'd2;

    localparam int unsigned BASE_W = 6;
    typedef logic [BASE_W-1:0] radix_t;

    localparam radix_t RADIX_AUTO = 6'd0;
    localparam radix_t RADIX_ONE  = 6'd1;
    localparam radix_t RADIX_MIN  = 6'd2;
    localparam radix_t RADIX_OCT  = 6'd8;
    localparam radix_t RADIX_DEC  = 6'd10;
    localparam radix_t RADIX_HEX  = 6'd16;
    localparam radix_t RADIX_MAX  = 6'd36;

    // Character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

    // Offsets from character code to digit value
    localparam logic [7:0] OFS_LOWER = 8'h57;
    localparam logic [7:0] OFS_UPPER = 8'h37;
    localparam logic [7:0] OFS_DIGIT = 8'h30;

    typedef struct packed {
        logic   blank;
        logic   plus;
        logic   minus;
        logic   zero;
        logic   hex_x;
        logic   alnum;
        radix_t digit;
    } char_class_t;

endpackage

// ----- src/strp_decode.sv -----
// Character classifier: white space, sign, prefix letters and digit value.
module strp_decode
(
    input  logic [7:0]           char_code,
    output strp_pkg::char_class_t cls
);

    logic       is_lower;
    logic       is_upper;
    logic       is_num;
    logic [7:0] value_wide;

    always_comb
    begin
        is_lower = (char_code >= strp_pkg::CHAR_LO_A) && (char_code <= strp_pkg::CHAR_LO_Z);
        is_upper = (char_code >= strp_pkg::CHAR_UP_A) && (char_code <= strp_pkg::CHAR_UP_Z);
        is_num   = (char_code >= strp_pkg::CHAR_ZERO) && (char_code <= strp_pkg::CHAR_NINE);

        if (is_lower)
            value_wide = char_code - strp_pkg::OFS_LOWER;
        else if (is_upper)
            value_wide = char_code - strp_pkg::OFS_UPPER;
        else
            value_wide = char_code - strp_pkg::OFS_DIGIT;

        cls.blank = (char_code == strp_pkg::CHAR_SPACE) ||
                    ((char_code >= strp_pkg::CHAR_TAB) && (char_code <= strp_pkg::CHAR_CR));
        cls.plus  = (char_code == strp_pkg::CHAR_PLUS);
        cls.minus = (char_code == strp_pkg::CHAR_MINUS);
        cls.zero  = (char_code == strp_pkg::CHAR_ZERO);
        cls.hex_x = (char_code == strp_pkg::CHAR_LO_X) || (char_code == strp_pkg::CHAR_UP_X);
        cls.alnum = is_lower || is_upper || is_num;
        cls.digit = value_wide[strp_pkg::BASE_W-1:0];
    end

endmodule

// ----- src/strp_core.sv -----
// Parse state, digit accumulator and result register.
module strp_core
#(
    parameter int unsigned OFFSET_BITS = 16,
    parameter int unsigned VALUE_BITS  = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_valid,
    input  logic [7:0]             s_char,
    input  logic                   s_last,
    output logic                   s_take,
    input  strp_pkg::radix_t       number_base,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_BITS-1:0]  parsed_value,
    output logic [OFFSET_BITS-1:0] end_offset,
    output strp_pkg::status_t      status
);

    localparam int unsigned PROD_W = VALUE_BITS + strp_pkg::BASE_W;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXPRE,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    strp_pkg::radix_t       base_reg, base_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] ds_reg, ds_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]  out_raw_reg, out_raw_next;
    logic                   out_neg_reg, out_neg_next;
    logic [OFFSET_BITS-1:0] out_ofs_reg, out_ofs_next;
    strp_pkg::status_t      out_status_reg, out_status_next;

    strp_pkg::char_class_t  cls;
    logic                   fire;
    logic                   bad_cfg;
    logic                   auto_or_hex;
    logic                   do_take;
    strp_pkg::radix_t       take_base;
    strp_pkg::radix_t       start_base;
    logic                   digit_ok;
    logic [PROD_W-1:0]      prod;
    logic                   prod_ovf;
    logic [OFFSET_BITS-1:0] next_pos;

    strp_decode u_decode
    (
        .char_code (s_char),
        .cls       (cls)
    );

    // A non-final item never produces a result, so it never waits
    assign s_take = !s_last || !out_valid_reg || out_ready;
    assign fire   = s_valid && s_take;

    always_comb
    begin
        bad_cfg     = (number_base == strp_pkg::RADIX_ONE) || (number_base > strp_pkg::RADIX_MAX);
        auto_or_hex = (number_base == strp_pkg::RADIX_AUTO) || (number_base == strp_pkg::RADIX_HEX);
        start_base  = (number_base == strp_pkg::RADIX_AUTO) ? strp_pkg::RADIX_DEC : number_base;

        do_take   = 1'b0;
        take_base = base_reg;
        case (phase_reg)
            PH_SPACE:
            begin
                do_take   = !cls.blank && !cls.plus && !cls.minus && !bad_cfg &&
                            !(cls.zero && auto_or_hex);
                take_base = start_base;
            end
            PH_SIGNED:
            begin
                do_take   = !bad_cfg && !(cls.zero && auto_or_hex);
                take_base = start_base;
            end
            PH_ZERO:
            begin
                do_take   = !cls.hex_x;
                take_base = (base_reg == strp_pkg::RADIX_AUTO) ? strp_pkg::RADIX_OCT
                                                               : strp_pkg::RADIX_HEX;
            end
            PH_HEXPRE, PH_DIGITS:
            begin
                do_take   = 1'b1;
                take_base = base_reg;
            end
            default:
            begin
                do_take   = 1'b0;
                take_base = base_reg;
            end
        endcase

        digit_ok = cls.alnum && (cls.digit < take_base) && (take_base >= strp_pkg::RADIX_MIN);
        prod     = PROD_W'(acc_reg) * PROD_W'(take_base) + PROD_W'(cls.digit);
        prod_ovf = |prod[PROD_W-1:VALUE_BITS];
        next_pos = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        ds_next    = ds_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_raw_next    = out_raw_reg;
        out_neg_next    = out_neg_reg;
        out_ofs_next    = out_ofs_reg;
        out_status_next = out_status_reg;

        if (fire)
        begin
            pos_next = next_pos;

            if (do_take)
            begin
                base_next = take_base;
                if (digit_ok)
                begin
                    if (!ovf_reg)
                    begin
                        if (prod_ovf)
                        begin
                            ovf_next = 1'b1;
                            acc_next = '1;
                        end
                        else
                            acc_next = prod[VALUE_BITS-1:0];
                    end
                    ds_next    = next_pos;
                    phase_next = PH_DIGITS;
                end
                else
                    phase_next = PH_DONE;
            end
            else
            begin
                case (phase_reg)
                    PH_SPACE, PH_SIGNED:
                    begin
                        if (phase_reg == PH_SPACE && (cls.plus || cls.minus))
                        begin
                            neg_next   = cls.minus;
                            phase_next = PH_SIGNED;
                        end
                        else if (phase_reg == PH_SPACE && cls.blank)
                            phase_next = PH_SPACE;
                        else if (bad_cfg)
                            phase_next = PH_DONE;
                        else
                        begin
                            // leading zero: radix may still turn hex
                            base_next  = number_base;
                            acc_next   = '0;
                            ds_next    = next_pos;
                            phase_next = PH_ZERO;
                        end
                    end
                    PH_ZERO:
                    begin
                        base_next  = strp_pkg::RADIX_HEX;
                        phase_next = PH_HEXPRE;
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end

            if (s_last)
            begin
                out_valid_next = 1'b1;
                out_neg_next   = 1'b0;
                if (ds_next == '0)
                begin
                    out_raw_next    = '0;
                    out_ofs_next    = '0;
                    out_status_next = strp_pkg::STATUS_NO_DIGITS;
                end
                else if (ovf_next)
                begin
                    out_raw_next    = '1;
                    out_ofs_next    = ds_next;
                    out_status_next = strp_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    out_raw_next    = acc_next;
                    out_neg_next    = neg_next;
                    out_ofs_next    = ds_next;
                    out_status_next = strp_pkg::STATUS_OK;
                end

                // drop parse state ready for the next string
                phase_next = PH_SPACE;
                acc_next   = '0;
                base_next  = strp_pkg::RADIX_AUTO;
                neg_next   = 1'b0;
                ovf_next   = 1'b0;
                pos_next   = '0;
                ds_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            acc_reg       <= '0;
            base_reg      <= strp_pkg::RADIX_AUTO;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            ds_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            base_reg      <= base_next;
            neg_reg       <= neg_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            ds_reg        <= ds_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_raw_reg    <= out_raw_next;
        out_neg_reg    <= out_neg_next;
        out_ofs_reg    <= out_ofs_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign parsed_value = out_neg_reg ? (~out_raw_reg + 1'b1) : out_raw_reg;
    assign end_offset   = out_ofs_reg;
    assign status       = out_status_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s_last |=> phase_reg == PH_SPACE && pos_reg == '0 && ds_reg == '0)
        else $error("parse state not cleared after final item");

    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == strp_pkg::STATUS_NO_DIGITS |->
            out_raw_reg == '0 && out_ofs_reg == '0 && !out_neg_reg)
        else $error("no-digit result carries a value or offset");

    a_overflow_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == strp_pkg::STATUS_OVERFLOW |->
            (&out_raw_reg) && !out_neg_reg && out_ofs_reg != '0)
        else $error("overflow result not pinned at all ones");

    a_digit_radix: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIGITS |->
            base_reg >= strp_pkg::RADIX_MIN && base_reg <= strp_pkg::RADIX_MAX &&
            ds_reg != '0)
        else $error("digit phase with invalid radix or no digit offset");

    a_ovf_acc: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (&acc_reg))
        else $error("overflow flag set with accumulator not saturated");

endmodule

// ----- src/string_to_unsigned_parser.sv -----
// Top level: streaming strtoul-style parser with input register and config register.
//
// Input channel (in_valid/in_ready): one character per item in char_in, with
// is_last high on the final character of a string. Output channel
// (out_valid/out_ready): one result item per string, given for the item
// flagged last: parsed_value, end_offset and status (ok, overflow, no digits).
// Configuration: cfg_write loads cfg_data into number_base in the same edge;
// 0 selects the radix from the 0x / 0 prefix, 2 to 36 fixes it.
//
// Throughput is one character per cycle unless a final character waits on a held
// result: the digit step is one multiply by the 6-bit radix plus add and overflow
// test between the input register and the parse state. The final character passes
// through the input register, then the result register, before out_valid.
// When the receiver stalls, the result register holds its item; characters
// keep flowing until the next final character, which waits in the input
// register until the held result is taken.
// Reset clears the parse state, empties both registers and sets number_base
// to automatic detection.
module string_to_unsigned_parser
#(
    parameter int unsigned OFFSET_BITS = 16,
    parameter int unsigned VALUE_BITS  = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [5:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             char_in,
    input  logic                   is_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_BITS-1:0]  parsed_value,
    output logic [OFFSET_BITS-1:0] end_offset,
    output logic [1:0]             status
);

    strp_pkg::radix_t base_reg;
    logic             s_valid_reg, s_valid_next;
    logic [7:0]       s_char_reg;
    logic             s_last_reg;
    logic             s_take;

    assign in_ready = !s_valid_reg || s_take;

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (in_valid && in_ready)
            s_valid_next = 1'b1;
        else if (s_take)
            s_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= strp_pkg::RADIX_AUTO;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                base_reg <= cfg_data;
            s_valid_reg <= s_valid_next;
        end
    end

    // hold the character until the core takes it
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s_char_reg <= char_in;
            s_last_reg <= is_last;
        end
    end

    strp_core
    #(
        .OFFSET_BITS (OFFSET_BITS),
        .VALUE_BITS  (VALUE_BITS)
    )
    u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_valid_reg),
        .s_char       (s_char_reg),
        .s_last       (s_last_reg),
        .s_take       (s_take),
        .number_base  (base_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parsed_value (parsed_value),
        .end_offset   (end_offset),
        .status       (status)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the streaming string-to-unsigned parser.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned OFFSET_W = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PERCENT   = 27;
    localparam int STALL_CYCLES   = 300;
    localparam int RANDOM_CHARS   = 200;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_VT   = 8'h0B;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam logic [7:0] CHAR_HIGH = 8'h80;
    localparam logic [7:0] CHAR_TOP  = 8'hFF;

    typedef enum logic [2:0] {
        SCAN_BLANK,
        SCAN_SIGNED,
        SCAN_ZERO,
        SCAN_HEXPRE,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] offset;
        strp_pkg::status_t   code;
    } parse_result_t;

    typedef logic [7:0] text_t[$];

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_write = 1'b0;
    logic [5:0]          cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [7:0]          char_in   = '0;
    logic                is_last   = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [VALUE_W-1:0]  parsed_value;
    logic [OFFSET_W-1:0] end_offset;
    logic [1:0]          status;

    // Mirror of the parse state
    strp_pkg::radix_t    radix_setting = strp_pkg::RADIX_AUTO;
    scan_t               scan_phase    = SCAN_BLANK;
    logic [VALUE_W-1:0]  acc_value     = '0;
    int unsigned         cur_base      = 0;
    bit                  neg_sign      = 1'b0;
    bit                  ovf_seen      = 1'b0;
    logic [OFFSET_W-1:0] char_pos      = '0;
    logic [OFFSET_W-1:0] digits_end    = '0;

    parse_result_t expected_results[$];
    int  error_count  = 0;
    int  chars_sent   = 0;
    int  quiet_cycles = 0;
    int  stall_asked  = 0;
    int  stall_taken  = 0;
    int  stall_left   = 0;
    bit  steady       = 1'b0;

    string_to_unsigned_parser #(
        .OFFSET_BITS (OFFSET_W),
        .VALUE_BITS  (VALUE_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_in      (char_in),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parsed_value (parsed_value),
        .end_offset   (end_offset),
        .status       (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Try c as a digit of the captured radix; a non-digit closes the number
    task automatic take_digit(input logic [7:0] c, input logic [OFFSET_W-1:0] nxt);
        int unsigned d;
        logic [VALUE_W+7:0] wide;
        if (c >= strp_pkg::CHAR_LO_A && c <= strp_pkg::CHAR_LO_Z)
            d = 32'(c - strp_pkg::OFS_LOWER);
        else if (c >= strp_pkg::CHAR_UP_A && c <= strp_pkg::CHAR_UP_Z)
            d = 32'(c - strp_pkg::OFS_UPPER);
        else if (c >= strp_pkg::CHAR_ZERO && c <= strp_pkg::CHAR_NINE)
            d = 32'(c - strp_pkg::OFS_DIGIT);
        else
            d = 99;
        if (d >= cur_base || cur_base < strp_pkg::RADIX_MIN)
        begin
            scan_phase = SCAN_DONE;
            return;
        end
        if (!ovf_seen)
        begin
            wide = (VALUE_W + 8)'(acc_value) * (VALUE_W + 8)'(cur_base) + (VALUE_W + 8)'(d);
            if (wide[VALUE_W+7:VALUE_W] != '0)
            begin
                ovf_seen  = 1'b1;
                acc_value = '1;
            end
            else
                acc_value = wide[VALUE_W-1:0];
        end
        digits_end = nxt;
        scan_phase = SCAN_DIGITS;
    endtask

    // First character after blanks and sign: capture the radix here
    task automatic start_number(input logic [7:0] c, input logic [OFFSET_W-1:0] nxt);
        int unsigned setting;
        setting = 32'(radix_setting);
        if (setting == strp_pkg::RADIX_ONE || setting > strp_pkg::RADIX_MAX)
        begin
            scan_phase = SCAN_DONE;
            return;
        end
        if (c == strp_pkg::CHAR_ZERO &&
            (setting == strp_pkg::RADIX_AUTO || setting == strp_pkg::RADIX_HEX))
        begin
            cur_base   = setting;
            acc_value  = '0;
            digits_end = nxt;
            scan_phase = SCAN_ZERO;
            return;
        end
        cur_base = (setting == strp_pkg::RADIX_AUTO) ? 32'(strp_pkg::RADIX_DEC) : setting;
        take_digit(c, nxt);
    endtask

    task automatic parse_char(input logic [7:0] c, input logic final_char);
        logic [OFFSET_W-1:0] nxt;
        parse_result_t res;
        nxt = (char_pos == '1) ? char_pos : char_pos + 1'b1;
        case (scan_phase)
            SCAN_BLANK:
                if (c == strp_pkg::CHAR_SPACE ||
                    (c >= strp_pkg::CHAR_TAB && c <= strp_pkg::CHAR_CR))
                    ;
                else if (c == strp_pkg::CHAR_PLUS || c == strp_pkg::CHAR_MINUS)
                begin
                    neg_sign   = (c == strp_pkg::CHAR_MINUS);
                    scan_phase = SCAN_SIGNED;
                end
                else
                    start_number(c, nxt);
            SCAN_SIGNED:
                start_number(c, nxt);
            SCAN_ZERO:
                if (c == strp_pkg::CHAR_LO_X || c == strp_pkg::CHAR_UP_X)
                begin
                    cur_base   = 32'(strp_pkg::RADIX_HEX);
                    scan_phase = SCAN_HEXPRE;
                end
                else
                begin
                    cur_base = (cur_base == strp_pkg::RADIX_AUTO) ? 32'(strp_pkg::RADIX_OCT)
                                                                  : 32'(strp_pkg::RADIX_HEX);
                    take_digit(c, nxt);
                end
            SCAN_HEXPRE, SCAN_DIGITS:
                take_digit(c, nxt);
            default:
                ;
        endcase
        char_pos = nxt;
        if (final_char)
        begin
            if (digits_end == '0)
                res = '{value: '0, offset: '0, code: strp_pkg::STATUS_NO_DIGITS};
            else if (ovf_seen)
                res = '{value: '1, offset: digits_end, code: strp_pkg::STATUS_OVERFLOW};
            else
                res = '{value: neg_sign ? ('0 - acc_value) : acc_value,
                        offset: digits_end, code: strp_pkg::STATUS_OK};
            expected_results.push_back(res);
            scan_phase = SCAN_BLANK;
            acc_value  = '0;
            cur_base   = 0;
            neg_sign   = 1'b0;
            ovf_seen   = 1'b0;
            char_pos   = '0;
            digits_end = '0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance with valid held
    task automatic send_item(input logic [7:0] c, input logic final_char);
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < IDLE_PERCENT);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        is_last  <= final_char;
        do
            @(posedge clk);
        while (!in_ready);
        parse_char(c, final_char);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input text_t t, input bit closes = 1'b1);
        for (int i = 0; i < t.size(); i++)
            send_item(t[i], closes && (i == t.size() - 1));
    endtask

    function automatic text_t str_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    // Drop valid and hold until every pending string has reported
    task automatic wait_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Input must be idle and all results in; allow the pipeline to settle first
    task automatic set_radix(input strp_pkg::radix_t r);
        repeat (4) @(negedge clk);
        cfg_write     <= 1'b1;
        cfg_data      <= r;
        radix_setting = r;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic test_auto_radix();
        send_text(str_text("0"));
        send_item(strp_pkg::CHAR_SPACE, 1'b0);
        send_item(strp_pkg::CHAR_TAB, 1'b0);
        send_item(CHAR_LF, 1'b0);
        send_item(CHAR_VT, 1'b0);
        send_item(CHAR_FF, 1'b0);
        send_item(strp_pkg::CHAR_CR, 1'b0);
        send_text(str_text("+123"));
        send_text(str_text("-1"));
        send_text(str_text("0x1aF"));
        send_text(str_text("0X"));
        send_text(str_text("0xg"));
        send_text(str_text("017"));
        send_text(str_text("08"));
        send_text(str_text("18446744073709551615"));
        send_text(str_text("18446744073709551616"));
        send_text(str_text("-99999999999999999999"));
        send_text(str_text("0xFFFFFFFFFFFFFFFF"));
        send_text(str_text("0x10000000000000000"));
        send_text(str_text("x"));
        send_text(str_text("-"));
        send_item(strp_pkg::CHAR_SPACE, 1'b1);
        send_text(str_text("12abc"));
        send_text(str_text("12"), 1'b0);
        send_item(CHAR_NUL, 1'b0);
        send_text(str_text(" 9"));
        send_text(str_text("7"), 1'b0);
        send_item(CHAR_TOP, 1'b1);
        send_item(CHAR_HIGH, 1'b1);
        wait_results();
    endtask

    task automatic test_fixed_radix();
        set_radix(strp_pkg::RADIX_MIN);
        send_text(str_text("101"));
        send_text(str_text("-11"));
        send_text(str_text("2"));
        wait_results();
        set_radix(strp_pkg::RADIX_OCT);
        send_text(str_text("0x1"));
        send_text(str_text("777"));
        wait_results();
        set_radix(strp_pkg::RADIX_HEX);
        send_text(str_text("0xff"));
        send_text(str_text("0x"));
        send_text(str_text("-0XaBc"));
        wait_results();
        set_radix(strp_pkg::RADIX_MAX);
        send_text(str_text("zZ"));
        send_text(str_text("0x"));
        wait_results();
        set_radix(strp_pkg::RADIX_ONE);
        send_text(str_text("1"));
        wait_results();
        set_radix(strp_pkg::RADIX_MAX + 1'b1);
        send_text(str_text("1"));
        wait_results();
        set_radix('1);
        send_text(str_text("5"));
        wait_results();
    endtask

    // The radix is latched by the first character after blanks and sign
    task automatic test_radix_change_mid_string();
        set_radix(strp_pkg::RADIX_DEC);
        send_text(str_text(" -"), 1'b0);
        wait_results();
        set_radix(strp_pkg::RADIX_HEX);
        send_text(str_text("fF"));
        send_text(str_text("12"), 1'b0);
        wait_results();
        set_radix(strp_pkg::RADIX_MIN);
        send_text(str_text("9a"));
        wait_results();
        set_radix(strp_pkg::RADIX_AUTO);
        send_text(str_text("0"), 1'b0);
        wait_results();
        set_radix(strp_pkg::RADIX_DEC);
        send_text(str_text("x1"));
        wait_results();
        set_radix(strp_pkg::RADIX_AUTO);
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_stall();
        steady = 1'b1;
        stall_asked++;
        repeat (6)
        begin
            send_text(str_text("+42"));
            send_text(str_text("0x7"));
        end
        wait_results();
        steady = 1'b0;
    endtask

    task automatic test_random_strings();
        int first;
        int phase_no;
        int n;
        int base;
        int d;
        strp_pkg::radix_t r;
        text_t t;
        first    = chars_sent;
        phase_no = 0;
        while (chars_sent - first < RANDOM_CHARS)
        begin
            case ($urandom_range(7))
                0, 1: r = strp_pkg::RADIX_AUTO;
                2:    r = strp_pkg::RADIX_DEC;
                3:    r = strp_pkg::RADIX_HEX;
                4:    r = strp_pkg::RADIX_OCT;
                5:    r = strp_pkg::RADIX_MIN;
                6:    r = strp_pkg::RADIX_MAX;
                default: r = strp_pkg::radix_t'($urandom_range(63));
            endcase
            wait_results();
            set_radix(r);
            steady = (phase_no == 1);
            repeat (8)
            begin
                t = {};
                if ($urandom_range(9) == 0)
                begin
                    // noise
                    repeat ($urandom_range(1, 5)) t.push_back(8'($urandom_range(255)));
                end
                else
                begin
                    repeat ($urandom_range(3))
                        if ($urandom_range(5) == 0)
                            t.push_back(strp_pkg::CHAR_SPACE);
                        else
                            t.push_back(strp_pkg::CHAR_TAB + 8'($urandom_range(4)));
                    case ($urandom_range(3))
                        0: t.push_back(strp_pkg::CHAR_PLUS);
                        1: t.push_back(strp_pkg::CHAR_MINUS);
                        default: ;
                    endcase
                    base = (r == strp_pkg::RADIX_ONE || r > strp_pkg::RADIX_MAX)
                           ? int'(strp_pkg::RADIX_DEC) : int'(r);
                    if (r == strp_pkg::RADIX_AUTO || r == strp_pkg::RADIX_HEX)
                        case ($urandom_range(3))
                            0:
                            begin
                                t.push_back(strp_pkg::CHAR_ZERO);
                                t.push_back($urandom_range(1) ? strp_pkg::CHAR_LO_X
                                                              : strp_pkg::CHAR_UP_X);
                                base = int'(strp_pkg::RADIX_HEX);
                            end
                            1:
                            begin
                                t.push_back(strp_pkg::CHAR_ZERO);
                                if (r == strp_pkg::RADIX_AUTO)
                                    base = int'(strp_pkg::RADIX_OCT);
                            end
                            default: ;
                        endcase
                    if (base == strp_pkg::RADIX_AUTO)
                        base = int'(strp_pkg::RADIX_DEC);
                    n = ($urandom_range(7) == 0) ? $urandom_range(15, 30) : $urandom_range(6);
                    repeat (n)
                    begin
                        d = $urandom_range(base - 1);
                        if (d < 10)
                            t.push_back(strp_pkg::CHAR_ZERO + 8'(d));
                        else
                            t.push_back(($urandom_range(1) ? strp_pkg::CHAR_LO_A
                                                           : strp_pkg::CHAR_UP_A) + 8'(d - 10));
                    end
                    if ($urandom_range(3) == 0)
                        repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(255)));
                end
                if (t.size() == 0)
                    t.push_back(8'($urandom_range(255)));
                send_text(t);
            end
            phase_no++;
        end
        steady = 1'b0;
        wait_results();
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_auto_radix();
        test_fixed_radix();
        test_radix_change_mid_string();
        test_output_stall();
        test_random_strings();
        wait_results();
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("string_to_unsigned_parser verification clean");
        else
            $display("string_to_unsigned_parser verification failed");
        $finish;
    end

    // Receiver: random back-pressure, or a counted hold-off when asked
    always @(negedge clk)
    begin
        if (stall_taken != stall_asked)
        begin
            stall_taken = stall_asked;
            stall_left  = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no string pending: parsed_value %h", parsed_value);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (parsed_value !== want.value)
                begin
                    $error("parsed_value expected %h got %h", want.value, parsed_value);
                    error_count++;
                end
                if (end_offset !== want.offset)
                begin
                    $error("end_offset expected %0d got %0d", want.offset, end_offset);
                    error_count++;
                end
                if (status !== want.code)
                begin
                    $error("status expected %0d got %0d", want.code, status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("string_to_unsigned_parser verification failed");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
src/strp_pkg.sv
src/strp_decode.sv
src/strp_core.sv
src/string_to_unsigned_parser.sv
tb/tb_top.sv
